>>> rtl/core/wavhp_pkg.sv
// Shared types and constants for the WAV header chunk parser.
package wavhp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// fmt body bytes captured, and the offsets of the fields within it
	localparam logic [3:0] FMT_LAST_K  = 4'd15;
	localparam logic [3:0] K_CH_LO     = 4'd2;
	localparam logic [3:0] K_CH_HI     = 4'd3;
	localparam logic [3:0] K_RATE_0    = 4'd4;
	localparam logic [3:0] K_RATE_1    = 4'd5;
	localparam logic [3:0] K_RATE_2    = 4'd6;
	localparam logic [3:0] K_RATE_3    = 4'd7;
	localparam logic [3:0] K_BITS_LO   = 4'd14;
	localparam logic [3:0] K_BITS_HI   = 4'd15;

	localparam logic [2:0] TAG_LAST_IDX = 3'd3;
	localparam logic [2:0] HDR_LAST_IDX = 3'd7;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_RSIZE,
		PH_WAVE,
		PH_HDR,
		PH_SKIP,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic        emit;
		logic        header_valid;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic [31:0] body_offset;
		logic [31:0] body_length;
	} res_t;

endpackage

>>> rtl/core/wavhp_core.sv
// Per-byte parser state and the next-state logic for one header byte.
module wavhp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output wavhp_pkg::res_t     res
);
	import wavhp_pkg::*;

	phase_t      phase_q, phase_nx;
	logic [31:0] pos_q, pos_nx;
	logic [31:0] tag_q, tag_nx;
	logic [31:0] size_q, size_nx;
	logic [32:0] skip_q, skip_nx;
	logic [2:0]  hbi_q, hbi_nx;
	logic [4:0]  fci_q, fci_nx;
	logic [15:0] sh_ch_q, sh_ch_nx;
	logic [31:0] sh_rate_q, sh_rate_nx;
	logic [15:0] sh_bits_q, sh_bits_nx;
	logic [15:0] hd_ch_q, hd_ch_nx;
	logic [31:0] hd_rate_q, hd_rate_nx;
	logic [15:0] hd_bits_q, hd_bits_nx;
	logic        fmt_seen_q, fmt_seen_nx;
	logic        riff_ok_q, riff_ok_nx;
	logic        sent_q, sent_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RIFF;
			pos_q      <= '0;
			tag_q      <= '0;
			size_q     <= '0;
			skip_q     <= '0;
			hbi_q      <= '0;
			fci_q      <= '0;
			sh_ch_q    <= '0;
			sh_rate_q  <= '0;
			sh_bits_q  <= '0;
			hd_ch_q    <= '0;
			hd_rate_q  <= '0;
			hd_bits_q  <= '0;
			fmt_seen_q <= 1'b0;
			riff_ok_q  <= 1'b0;
			sent_q     <= 1'b0;
		end else if (step_en) begin
			phase_q    <= phase_nx;
			pos_q      <= pos_nx;
			tag_q      <= tag_nx;
			size_q     <= size_nx;
			skip_q     <= skip_nx;
			hbi_q      <= hbi_nx;
			fci_q      <= fci_nx;
			sh_ch_q    <= sh_ch_nx;
			sh_rate_q  <= sh_rate_nx;
			sh_bits_q  <= sh_bits_nx;
			hd_ch_q    <= hd_ch_nx;
			hd_rate_q  <= hd_rate_nx;
			hd_bits_q  <= hd_bits_nx;
			fmt_seen_q <= fmt_seen_nx;
			riff_ok_q  <= riff_ok_nx;
			sent_q     <= sent_nx;
		end
	end

	always_comb begin
		logic [3:0]  k;
		logic [31:0] tag_sh;
		logic [31:0] size_sh;
		logic [32:0] skip_dec;

		phase_nx    = phase_q;
		pos_nx      = pos_q + 32'd1;
		tag_nx      = tag_q;
		size_nx     = size_q;
		skip_nx     = skip_q;
		hbi_nx      = hbi_q;
		fci_nx      = fci_q;
		sh_ch_nx    = sh_ch_q;
		sh_rate_nx  = sh_rate_q;
		sh_bits_nx  = sh_bits_q;
		hd_ch_nx    = hd_ch_q;
		hd_rate_nx  = hd_rate_q;
		hd_bits_nx  = hd_bits_q;
		fmt_seen_nx = fmt_seen_q;
		riff_ok_nx  = riff_ok_q;
		sent_nx     = sent_q;
		res         = '0;

		k        = fci_q[3:0] - 4'd1;
		tag_sh   = {data_byte, tag_q[31:8]};
		size_sh  = {data_byte, size_q[31:8]};
		skip_dec = skip_q - 33'd1;

		// fmt body capture runs alongside chunk walking
		if ((phase_q == PH_HDR || phase_q == PH_SKIP) && fci_q != 5'd0) begin
			case (k)
				K_CH_LO:   sh_ch_nx[7:0]     = data_byte;
				K_CH_HI:   sh_ch_nx[15:8]    = data_byte;
				K_RATE_0:  sh_rate_nx[7:0]   = data_byte;
				K_RATE_1:  sh_rate_nx[15:8]  = data_byte;
				K_RATE_2:  sh_rate_nx[23:16] = data_byte;
				K_RATE_3:  sh_rate_nx[31:24] = data_byte;
				K_BITS_LO: sh_bits_nx[7:0]   = data_byte;
				K_BITS_HI: sh_bits_nx[15:8]  = data_byte;
				default: ;
			endcase
			if (k == FMT_LAST_K) begin
				hd_ch_nx    = sh_ch_nx;
				hd_rate_nx  = sh_rate_nx;
				hd_bits_nx  = sh_bits_nx;
				fmt_seen_nx = 1'b1;
				fci_nx      = 5'd0;
			end else begin
				fci_nx = fci_q + 5'd1;
			end
		end

		case (phase_q)
			PH_RIFF, PH_WAVE: begin
				tag_nx = tag_sh;
				if (hbi_q == TAG_LAST_IDX) begin
					hbi_nx = '0;
					if (phase_q == PH_RIFF) begin
						phase_nx = (tag_sh == TAG_RIFF) ? PH_RSIZE : PH_DONE;
					end else if (tag_sh == TAG_WAVE) begin
						riff_ok_nx = 1'b1;
						phase_nx   = PH_HDR;
					end else begin
						phase_nx = PH_DONE;
					end
				end else begin
					hbi_nx = hbi_q + 3'd1;
				end
			end
			PH_RSIZE: begin
				if (hbi_q == TAG_LAST_IDX) begin
					hbi_nx   = '0;
					phase_nx = PH_WAVE;
				end else begin
					hbi_nx = hbi_q + 3'd1;
				end
			end
			PH_HDR: begin
				if (!hbi_q[2]) tag_nx = tag_sh;
				else size_nx = size_sh;
				if (hbi_q == HDR_LAST_IDX) begin
					hbi_nx = '0;
					if (tag_q == TAG_DATA && riff_ok_q) begin
						res.emit         = 1'b1;
						res.header_valid = fmt_seen_nx;
						if (fmt_seen_nx) begin
							res.channel_count = hd_ch_nx;
							res.rate_hz       = hd_rate_nx;
							res.sample_bits   = hd_bits_nx;
							res.body_offset   = pos_nx;
							res.body_length   = size_sh;
						end
						sent_nx  = 1'b1;
						phase_nx = PH_DONE;
					end else begin
						skip_nx = {1'b0, size_sh} + {32'd0, size_sh[0]};
						if (tag_q == TAG_FMT) begin
							fci_nx     = 5'd1;
							sh_ch_nx   = '0;
							sh_rate_nx = '0;
							sh_bits_nx = '0;
						end
						phase_nx = (skip_nx != 33'd0) ? PH_SKIP : PH_HDR;
					end
				end else begin
					hbi_nx = hbi_q + 3'd1;
				end
			end
			PH_SKIP: begin
				if (skip_q != 33'd0) skip_nx = skip_dec;
				if (skip_nx == 33'd0) phase_nx = PH_HDR;
			end
			default: ;
		endcase

		// end of buffer: report once if nothing was sent, then start over
		if (last_byte) begin
			if (!res.emit && !sent_q) begin
				res      = '0;
				res.emit = 1'b1;
			end
			phase_nx    = PH_RIFF;
			pos_nx      = '0;
			tag_nx      = '0;
			size_nx     = '0;
			skip_nx     = '0;
			hbi_nx      = '0;
			fci_nx      = '0;
			sh_ch_nx    = '0;
			sh_rate_nx  = '0;
			sh_bits_nx  = '0;
			hd_ch_nx    = '0;
			hd_rate_nx  = '0;
			hd_bits_nx  = '0;
			fmt_seen_nx = 1'b0;
			riff_ok_nx  = 1'b0;
			sent_nx     = 1'b0;
		end
	end

endmodule

>>> rtl/core/wav_header_chunk_parser.sv
// Top level of the streaming RIFF/WAVE header parser.
//
// Input channel: one header byte per request on data_byte, with
// last_byte set on the final byte of the buffer. Output channel: at most
// one result per buffer, carrying header_valid, the fmt fields, the data
// body offset and the data chunk size; fields are zero when the header
// is invalid.
// A result is emitted on the byte that completes the data chunk header,
// or on the last byte if no data chunk was reached. Bytes after that are
// consumed without effect until the last byte, which rearms the parser.
// An accepted byte is first held in the input register; it is parsed
// from there, and its result, if any, goes into the result register
// that drives the outputs. Throughput is one byte per cycle while the
// receiver does not stall a pending result; the per-byte update is a
// single pass of counter and shift logic.
// When the receiver stalls with a result pending, the block takes at most
// one more byte into its input register and then raises in_stall until
// the result is taken. Bytes that cause no result still wait for the
// result slot to free up.
// Reset (arst_n low) clears all parser state and drops any pending result.
module wav_header_chunk_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        header_valid,
	output logic [15:0] channel_count,
	output logic [31:0] rate_hz,
	output logic [15:0] sample_bits,
	output logic [31:0] body_offset,
	output logic [31:0] body_length
);
	import wavhp_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	res_t       res;
	res_t       res_q;
	logic       advance;
	logic       step_en;

	assign advance  = !out_valid_q || !out_stall;
	assign step_en  = v_s1 && advance;
	assign in_stall = v_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	wavhp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_en && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res.emit) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign header_valid  = res_q.header_valid;
	assign channel_count = res_q.channel_count;
	assign rate_hz       = res_q.rate_hz;
	assign sample_bits   = res_q.sample_bits;
	assign body_offset   = res_q.body_offset;
	assign body_length   = res_q.body_length;

endmodule

>>> rtl/core/wavhp_checker.sv
// Port-level checks for the WAV header parser, bound to the top level.
module wavhp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        header_valid,
	input logic [15:0] channel_count,
	input logic [31:0] rate_hz,
	input logic [15:0] sample_bits,
	input logic [31:0] body_offset,
	input logic [31:0] body_length
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(body_offset) && $stable(body_length)
			&& $stable(header_valid))
		else $error("stalled result changed");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !header_valid |-> channel_count == 16'd0 && rate_hz == 32'd0
			&& sample_bits == 16'd0 && body_offset == 32'd0 && body_length == 32'd0)
		else $error("invalid result carries nonzero fields");

	// chunks are padded to even length, so the data body starts even
	a_offset_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_valid |-> !body_offset[0])
		else $error("data offset is odd");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without a blocked result");

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid && !in_stall)
		else $error("activity during reset");

endmodule

bind wav_header_chunk_parser wavhp_checker u_wavhp_checker (.*);

>>> test/wav_header_chunk_parser_tb.sv
// Self-checking testbench for the streaming RIFF/WAVE header parser.
`timescale 1ns / 100ps

module wav_header_chunk_parser_tb;
	import wavhp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES = 300;
	localparam logic [31:0] LIST_TAG = 32'h5453_494C;

	typedef struct packed {
		logic        ok;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [15:0] sample_width;
		logic [31:0] offset;
		logic [31:0] length;
	} wav_info_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        header_valid;
	logic [15:0] channel_count;
	logic [31:0] rate_hz;
	logic [15:0] sample_bits;
	logic [31:0] body_offset;
	logic [31:0] body_length;

	wav_header_chunk_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.header_valid(header_valid),
		.channel_count(channel_count),
		.rate_hz(rate_hz),
		.sample_bits(sample_bits),
		.body_offset(body_offset),
		.body_length(body_length)
	);

	// parser state mirrored by the predictor
	phase_t      parse_ph;
	logic [31:0] byte_pos;
	logic [31:0] tag_sr;
	logic [31:0] size_sr;
	logic [32:0] skip_left;
	logic [2:0]  hdr_idx;
	logic [4:0]  cap_idx;
	logic [15:0] cap_ch;
	logic [31:0] cap_rate;
	logic [15:0] cap_bits;
	logic [15:0] fmt_ch;
	logic [31:0] fmt_rate;
	logic [15:0] fmt_bits;
	logic        fmt_ok;
	logic        wave_ok;
	logic        info_sent;

	wav_info_t   expected_headers[$];
	wav_info_t   head_info;
	logic [7:0]  byte_buf[$];
	int          mismatch_count = 0;
	int          bytes_sent = 0;
	int          cycle_count = 0;
	int          hold_req = 0;
	int          hold_done = 0;
	int          hold_left = 0;
	int          send_idle_pct;
	int          recv_stall_pct;

	always #5 clk = ~clk;

	function automatic void reset_parser();
		parse_ph = PH_RIFF;
		byte_pos = '0;
		tag_sr = '0;
		size_sr = '0;
		skip_left = '0;
		hdr_idx = '0;
		cap_idx = '0;
		cap_ch = '0;
		cap_rate = '0;
		cap_bits = '0;
		fmt_ch = '0;
		fmt_rate = '0;
		fmt_bits = '0;
		fmt_ok = 1'b0;
		wave_ok = 1'b0;
		info_sent = 1'b0;
	endfunction

	// Advance the parser by one byte; return 1 when the byte yields a header result.
	function automatic bit parse_header_byte(input logic [7:0] b, input logic lst,
			output wav_info_t r);
		bit got;
		logic [4:0] km1;
		logic [3:0] k;
		got = 1'b0;
		r = '0;
		if ((parse_ph == PH_HDR || parse_ph == PH_SKIP) && cap_idx != 0) begin
			km1 = cap_idx - 5'd1;
			k = km1[3:0];
			case (k)
				K_CH_LO: cap_ch[7:0] = b;
				K_CH_HI: cap_ch[15:8] = b;
				K_RATE_0: cap_rate[7:0] = b;
				K_RATE_1: cap_rate[15:8] = b;
				K_RATE_2: cap_rate[23:16] = b;
				K_RATE_3: cap_rate[31:24] = b;
				K_BITS_LO: cap_bits[7:0] = b;
				K_BITS_HI: cap_bits[15:8] = b;
				default: ;
			endcase
			if (k == FMT_LAST_K) begin
				fmt_ch = cap_ch;
				fmt_rate = cap_rate;
				fmt_bits = cap_bits;
				fmt_ok = 1'b1;
				cap_idx = '0;
			end else begin
				cap_idx = cap_idx + 5'd1;
			end
		end
		case (parse_ph)
			PH_RIFF, PH_WAVE: begin
				tag_sr = {b, tag_sr[31:8]};
				if (hdr_idx >= TAG_LAST_IDX) begin
					hdr_idx = '0;
					if (parse_ph == PH_RIFF) begin
						parse_ph = (tag_sr == TAG_RIFF) ? PH_RSIZE : PH_DONE;
					end else if (tag_sr == TAG_WAVE) begin
						wave_ok = 1'b1;
						parse_ph = PH_HDR;
					end else begin
						parse_ph = PH_DONE;
					end
				end else begin
					hdr_idx = hdr_idx + 3'd1;
				end
			end
			PH_RSIZE: begin
				if (hdr_idx >= TAG_LAST_IDX) begin
					hdr_idx = '0;
					parse_ph = PH_WAVE;
				end else begin
					hdr_idx = hdr_idx + 3'd1;
				end
			end
			PH_HDR: begin
				if (hdr_idx <= TAG_LAST_IDX)
					tag_sr = {b, tag_sr[31:8]};
				else
					size_sr = {b, size_sr[31:8]};
				if (hdr_idx >= HDR_LAST_IDX) begin
					hdr_idx = '0;
					if (tag_sr == TAG_DATA && wave_ok) begin
						got = 1'b1;
						r.ok = fmt_ok;
						if (fmt_ok) begin
							r.channels = fmt_ch;
							r.rate = fmt_rate;
							r.sample_width = fmt_bits;
							r.offset = byte_pos + 32'd1;
							r.length = size_sr;
						end
						info_sent = 1'b1;
						parse_ph = PH_DONE;
					end else begin
						// odd sizes carry one pad byte
						skip_left = {1'b0, size_sr} + {32'd0, size_sr[0]};
						if (tag_sr == TAG_FMT) begin
							cap_idx = 5'd1;
							cap_ch = '0;
							cap_rate = '0;
							cap_bits = '0;
						end
						parse_ph = (skip_left != 0) ? PH_SKIP : PH_HDR;
					end
				end else begin
					hdr_idx = hdr_idx + 3'd1;
				end
			end
			PH_SKIP: begin
				if (skip_left != 0)
					skip_left = skip_left - 33'd1;
				if (skip_left == 0)
					parse_ph = PH_HDR;
			end
			default: ;
		endcase
		byte_pos = byte_pos + 32'd1;
		if (lst) begin
			if (!got && !info_sent) begin
				got = 1'b1;
				r = '0;
			end
			reset_parser();
		end
		return got;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_headers.size() == 0) begin
				report_mismatch("result with none pending");
			end else begin
				head_info = expected_headers.pop_front();
				check_field("header_valid", 32'(header_valid), 32'(head_info.ok));
				check_field("channel_count", 32'(channel_count), 32'(head_info.channels));
				check_field("rate_hz", rate_hz, head_info.rate);
				check_field("sample_bits", 32'(sample_bits), 32'(head_info.sample_width));
				check_field("body_offset", body_offset, head_info.offset);
				check_field("body_length", body_length, head_info.length);
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when requested
	always @(negedge clk) begin
		if (hold_req != hold_done) begin
			hold_done = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		wav_info_t info;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (in_stall);
		if (parse_header_byte(b, lst, info))
			expected_headers.push_back(info);
		bytes_sent++;
	endtask

	task automatic send_buffer();
		int n;
		n = byte_buf.size();
		for (int i = 0; i < n; i++)
			send_byte(byte_buf[i], i == n - 1);
		byte_buf.delete();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_headers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_random_bytes(input int n);
		logic [7:0] v;
		for (int i = 0; i < n; i++) begin
			v = 8'($urandom_range(255));
			byte_buf.push_back(v);
		end
	endfunction

	function automatic void push_le32(input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			byte_buf.push_back(v[8*i +: 8]);
	endfunction

	function automatic void push_header(input logic [31:0] tag, input logic [31:0] len);
		push_le32(tag);
		push_le32(len);
	endfunction

	function automatic void push_chunk(input logic [31:0] tag, input logic [31:0] len);
		push_header(tag, len);
		push_random_bytes(int'(len) + int'(len[0]));
	endfunction

	function automatic void start_wave();
		push_le32(TAG_RIFF);
		push_random_bytes(4);
		push_le32(TAG_WAVE);
	endfunction

	// fmt chunk; a body shorter than 16 bytes is cut off at the declared size
	function automatic void push_fmt(input logic [31:0] len, input logic [15:0] ch,
			input logic [31:0] rate, input logic [15:0] bits);
		logic [7:0] body[16];
		int n;
		for (int i = 0; i < 16; i++)
			body[i] = 8'($urandom_range(255));
		{body[3], body[2]} = ch;
		{body[7], body[6], body[5], body[4]} = rate;
		{body[15], body[14]} = bits;
		push_header(TAG_FMT, len);
		n = int'(len) + int'(len[0]);
		for (int i = 0; i < n; i++) begin
			if (i < 16)
				byte_buf.push_back(body[i]);
			else
				push_random_bytes(1);
		end
	endfunction

	function automatic void build_random_buffer();
		int kind;
		int keep;
		logic [31:0] len;
		kind = $urandom_range(99);
		if (kind >= 90) begin
			push_random_bytes($urandom_range(30, 1));
			return;
		end
		start_wave();
		if (kind >= 85) begin
			// end the buffer deep inside a huge chunk
			push_header($urandom, 32'hFFFF_FFF0 | 32'($urandom_range(15)));
			push_random_bytes($urandom_range(6));
			return;
		end
		repeat ($urandom_range(3)) begin
			if ($urandom_range(1)) begin
				case ($urandom_range(3))
					0: len = 32'd16;
					1: len = 32'd18;
					default: len = $urandom_range(20);
				endcase
				push_fmt(len, 16'($urandom), $urandom, 16'($urandom));
			end else begin
				push_chunk($urandom, $urandom_range(7));
			end
		end
		if ($urandom_range(9) != 0) begin
			if ($urandom_range(1))
				len = $urandom;
			else
				len = $urandom_range(64);
			push_header(TAG_DATA, len);
			push_random_bytes($urandom_range(4));
		end
		if (kind >= 70) begin
			// break the buffer: flip a bit of a leading tag, or cut it short
			if ($urandom_range(1)) begin
				keep = $urandom_range(7);
				if (keep >= 4)
					keep += 4;
				byte_buf[keep] = byte_buf[keep] ^ (8'd1 << $urandom_range(7));
			end else begin
				keep = $urandom_range(byte_buf.size() - 1, 1);
				while (byte_buf.size() > keep)
					void'(byte_buf.pop_back());
			end
		end
	endfunction

	task automatic test_tag_checks();
		push_le32({8'h58, TAG_RIFF[23:0]});
		push_random_bytes(4);
		push_le32(TAG_WAVE);
		push_fmt(32'd16, 16'd2, 32'd44100, 16'd16);
		push_header(TAG_DATA, 32'd4);
		push_random_bytes(4);
		send_buffer();

		push_le32(TAG_RIFF);
		push_random_bytes(4);
		push_le32(TAG_WAVE ^ 32'h8000_0000);
		push_fmt(32'd16, 16'd1, 32'd8000, 16'd8);
		push_header(TAG_DATA, 32'd2);
		send_buffer();

		byte_buf.push_back(TAG_RIFF[7:0]);
		send_buffer();

		start_wave();
		void'(byte_buf.pop_back());
		send_buffer();
	endtask

	task automatic test_fmt_capture();
		start_wave();
		push_fmt(32'd16, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		push_header(TAG_DATA, 32'hFFFF_FFFF);
		push_random_bytes(3);
		send_buffer();

		// data header on the last byte
		start_wave();
		push_fmt(32'd16, 16'd0, 32'd0, 16'd0);
		push_chunk(LIST_TAG, 32'd3);
		push_header(TAG_DATA, 32'd0);
		send_buffer();

		// data chunk ahead of any fmt
		start_wave();
		push_header(TAG_DATA, 32'd16);
		push_fmt(32'd16, 16'd2, 32'd48000, 16'd24);
		send_buffer();

		// capture runs into the data header and commits on its last byte
		start_wave();
		push_fmt(32'd8, 16'd6, 32'd96000, 16'd32);
		push_header(TAG_DATA, 32'h1234_5678);
		push_random_bytes(2);
		send_buffer();

		// capture never finishes
		start_wave();
		push_fmt(32'd4, 16'd1, 32'd22050, 16'd8);
		push_header(TAG_DATA, 32'd2);
		push_random_bytes(2);
		send_buffer();

		// second fmt header restarts a running capture
		start_wave();
		push_fmt(32'd0, 16'd3, 32'd11025, 16'd12);
		push_fmt(32'd16, 16'd4, 32'd32000, 16'd20);
		push_header(TAG_DATA, 32'd10);
		send_buffer();

		// unfinished later fmt leaves the earlier one in place
		start_wave();
		push_fmt(32'd16, 16'd5, 32'd16000, 16'd16);
		push_fmt(32'd2, 16'd7, 32'd1, 16'd1);
		push_header(TAG_DATA, 32'd6);
		send_buffer();

		// later complete fmt overwrites
		start_wave();
		push_fmt(32'd16, 16'd5, 32'd16000, 16'd16);
		push_fmt(32'd18, 16'd8, 32'd192000, 16'd32);
		push_header(TAG_DATA, 32'd6);
		push_random_bytes(1);
		send_buffer();
	endtask

	task automatic test_chunk_sizes();
		// no data chunk before the end
		start_wave();
		push_fmt(32'd16, 16'd2, 32'd44100, 16'd16);
		push_chunk(LIST_TAG, 32'd5);
		send_buffer();

		start_wave();
		push_fmt(32'd16, 16'd2, 32'd44100, 16'd16);
		push_header(LIST_TAG, 32'hFFFF_FFFF);
		push_random_bytes(5);
		send_buffer();

		// odd fmt size with pad byte
		start_wave();
		push_fmt(32'd17, 16'd1, 32'd8000, 16'd8);
		push_header(TAG_DATA, 32'd1);
		push_random_bytes(2);
		send_buffer();
	endtask

	task automatic test_result_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req++;
		repeat (3) begin
			start_wave();
			push_fmt(32'd16, 16'($urandom), $urandom, 16'($urandom));
			push_header(TAG_DATA, 32'd8);
			push_random_bytes(8);
			send_buffer();
		end
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 7;
		recv_stall_pct = 50;
		repeat (2) begin
			start_wave();
			push_fmt(32'd16, 16'($urandom), $urandom, 16'($urandom));
			push_header(TAG_DATA, $urandom);
			send_buffer();
			wait_drained();
		end
	endtask

	task automatic test_random_traffic(input int send_pct, input int stall_pct,
			input int byte_goal);
		int start_count;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		start_count = bytes_sent;
		while (bytes_sent - start_count < byte_goal) begin
			build_random_buffer();
			send_buffer();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		reset_parser();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_tag_checks();
		test_fmt_capture();
		test_chunk_sizes();
		test_result_backpressure();
		test_drain_pause();
		test_random_traffic(0, 0, 240);
		test_random_traffic(74, 0, 240);
		test_random_traffic(0, 74, 240);
		test_random_traffic(7, 7, 240);
		wait_drained();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
